// ===== rtl/rhrt_pkg.sv =====
package rhrt_pkg;

  localparam int unsigned CoordW = 16;

  // Action codes of an input item.
  localparam logic ActAdd    = 1'b0;
  localparam logic ActLookup = 1'b1;

  // Alignment codes; the unused code places the left edge as explicit does.
  localparam logic [1:0] AlignExplicit = 2'd0;
  localparam logic [1:0] AlignCentre   = 2'd1;
  localparam logic [1:0] AlignRight    = 2'd2;
  localparam logic [1:0] AlignSpare    = 2'd3;

  localparam logic [CoordW-1:0] LineWidthReset = 16'd640;

  // Geometry of one stored area.
  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] span_x;
    logic [CoordW-1:0] span_y;
  } area_t;

  // One table entry as read back from the store.
  typedef struct packed {
    area_t             geom;
    logic [CoordW-1:0] label;
  } entry_t;

endpackage

// ===== rtl/rhrt_store.sv =====
module rhrt_store
  import rhrt_pkg::*;
#(
  parameter int unsigned COUNT = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_entry,
  input  logic             clear_labels,
  output entry_t           rd_entry
);

  area_t             geom_mem  [COUNT];
  logic [CoordW-1:0] label_mem [COUNT];
  logic [COUNT-1:0]  geom_vld;
  logic [COUNT-1:0]  label_vld;

  area_t             rd_geom;
  logic [CoordW-1:0] rd_label;
  logic              rd_geom_vld;
  logic              rd_label_vld;

  // Memory write and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      geom_mem[wr_addr]  <= wr_entry.geom;
      label_mem[wr_addr] <= wr_entry.label;
    end
    rd_geom  <= geom_mem[rd_addr];
    rd_label <= label_mem[rd_addr];
  end

  // Valid bits: reset empties the table, a clear drops only the labels.
  always_ff @(posedge clk) begin
    if (rst) begin
      geom_vld     <= '0;
      label_vld    <= '0;
      rd_geom_vld  <= 1'b0;
      rd_label_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        geom_vld[wr_addr] <= 1'b1;
      end
      if (clear_labels) begin
        label_vld <= '0;
      end else if (wr_en) begin
        label_vld[wr_addr] <= 1'b1;
      end
      rd_geom_vld  <= geom_vld[rd_addr];
      rd_label_vld <= label_vld[rd_addr];
    end
  end

  // An entry never written reads as all zero.
  always_comb begin
    rd_entry.geom  = rd_geom_vld  ? rd_geom  : '0;
    rd_entry.label = rd_label_vld ? rd_label : '0;
  end

endmodule

// ===== rtl/rhrt_entry_test.sv =====
module rhrt_entry_test
  import rhrt_pkg::*;
(
  input  logic   action,
  input  area_t  probe,
  input  entry_t entry,
  output logic   hit
);

  logic [CoordW:0] right_edge;
  logic [CoordW:0] bottom_edge;
  logic            covers;
  logic            usable;

  // Point containment, with bounds taken one bit wider so they never wrap.
  always_comb begin
    right_edge  = {1'b0, entry.geom.left} + {1'b0, entry.geom.span_x};
    bottom_edge = {1'b0, entry.geom.top}  + {1'b0, entry.geom.span_y};
    covers = (entry.geom.left <= probe.left) && ({1'b0, probe.left} <= right_edge) &&
             (entry.geom.top  <= probe.top)  && ({1'b0, probe.top}  <= bottom_edge);
  end

  // An add may use an entry with identical geometry or a free one.
  assign usable = (entry.geom == probe) || (entry.label == '0);

  assign hit = (action == ActLookup) ? covers : usable;

endmodule

// ===== rtl/rectangle_hit_region_table_top.sv =====
// Sequence: an accepted item passes through the ALIGN state and then the SCAN
// state, which tests entries until a hit or the last entry; a clear finishes in
// ALIGN without a scan. busy stays high until done, so a new item is taken
// only once the last one is through, as the single entry compare unit steps
// through the table memory one entry a cycle.
// Reset (rst, synchronous): the table reads as empty at once and the screen
// width register returns to 640. done is a one-cycle strobe; the receiver cannot stall.
module rectangle_hit_region_table_top
  import rhrt_pkg::*;
#(
  parameter int unsigned AREA_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              config_write,
  input  logic [CoordW-1:0] config_data,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [CoordW-1:0] x_position,
  input  logic [CoordW-1:0] y_position,
  input  logic [1:0]        align,
  input  logic [CoordW-1:0] area_width,
  input  logic [CoordW-1:0] area_height,
  input  logic [CoordW-1:0] area_tag,
  output logic              done,
  output logic [CoordW-1:0] found_tag,
  output logic              accepted
);

  localparam int unsigned IdxW = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(AREA_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ALIGN = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  state_t            state;
  logic [CoordW-1:0] screen_width;

  // Captured item.
  logic              it_action;
  logic [CoordW-1:0] it_x;
  logic [CoordW-1:0] it_y;
  logic [1:0]        it_align;
  logic [CoordW-1:0] it_w;
  logic [CoordW-1:0] it_h;
  logic [CoordW-1:0] it_tag;

  area_t             probe;
  logic [IdxW-1:0]   tst_idx;
  logic [IdxW-1:0]   rd_addr;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              wr_en;
  logic              clear_labels;
  logic              hit;
  logic              is_clear;

  logic signed [CoordW:0] diff;
  logic signed [CoordW:0] half;
  logic [CoordW-1:0]      left_next;

  assign busy = (state != ST_IDLE);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= LineWidthReset;
    end else if (config_write) begin
      screen_width <= config_data;
    end
  end

  // Left edge from the alignment mode; halving rounds toward zero.
  always_comb begin
    diff = $signed({1'b0, screen_width}) - $signed({1'b0, it_w});
    half = (diff + $signed({{CoordW{1'b0}}, diff[CoordW]})) >>> 1;
    unique case (it_align)
      AlignCentre: left_next = half[CoordW-1:0];
      AlignRight:  left_next = diff[CoordW-1:0];
      default:     left_next = it_x;
    endcase
  end

  assign is_clear = (it_action == ActAdd) && (it_align == AlignExplicit) &&
                    (it_x == '0) && (it_y == '0) && (it_w == '0) && (it_tag == '0);

  // Read address runs one entry ahead of the entry under test.
  assign rd_addr = (state == ST_SCAN && tst_idx != LastIdx) ? tst_idx + 1'b1 : '0;

  assign wr_entry.geom  = probe;
  assign wr_entry.label = it_tag;
  assign wr_en          = (state == ST_SCAN) && hit && (it_action == ActAdd);
  assign clear_labels   = (state == ST_ALIGN) && is_clear;

  rhrt_store #(
    .COUNT (AREA_COUNT),
    .IDX_W (IdxW)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (tst_idx),
    .wr_entry     (wr_entry),
    .clear_labels (clear_labels),
    .rd_entry     (rd_entry)
  );

  rhrt_entry_test u_test (
    .action (it_action),
    .probe  (probe),
    .entry  (rd_entry),
    .hit    (hit)
  );

  // Sequencer: capture, align, then scan the table one entry a cycle (not for a clear).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (is_clear) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit || tst_idx == LastIdx) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item capture, probe set-up, scan index and result beat.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          it_action <= action;
          it_x      <= x_position;
          it_y      <= y_position;
          it_align  <= align;
          it_w      <= area_width;
          it_h      <= area_height;
          it_tag    <= area_tag;
        end
      end
      ST_ALIGN: begin
        tst_idx      <= '0;
        probe.left   <= (it_action == ActLookup) ? it_x : left_next;
        probe.top    <= it_y;
        probe.span_x <= it_w;
        probe.span_y <= it_h;
        found_tag    <= '0;
        accepted     <= 1'b1;
      end
      ST_SCAN: begin
        tst_idx <= rd_addr;
        if (it_action == ActLookup) begin
          found_tag <= hit ? rd_entry.label : '0;
          accepted  <= 1'b1;
        end else begin
          found_tag <= '0;
          accepted  <= hit;
        end
      end
      default: begin
        tst_idx <= '0;
      end
    endcase
  end

endmodule

// ===== verif/tb_rectangle_hit_region_table_top.sv =====
module tb_rectangle_hit_region_table_top;
  import rhrt_pkg::*;

  localparam int unsigned Areas      = 16;
  localparam int unsigned PhaseBeats = 100;
  localparam int unsigned CycleLimit = 400000;

  // One command beat as presented on the input ports.
  typedef struct packed {
    logic              action;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [1:0]        align;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] tag;
  } hit_beat_t;

  // One result beat.
  typedef struct packed {
    logic [CoordW-1:0] tag;
    logic              ok;
  } hit_result_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              config_write = 1'b0;
  logic [CoordW-1:0] config_data  = '0;
  logic              start        = 1'b0;
  logic              busy;
  logic              action       = ActAdd;
  logic [CoordW-1:0] x_position   = '0;
  logic [CoordW-1:0] y_position   = '0;
  logic [1:0]        align        = AlignExplicit;
  logic [CoordW-1:0] area_width   = '0;
  logic [CoordW-1:0] area_height  = '0;
  logic [CoordW-1:0] area_tag     = '0;
  logic              done;
  logic [CoordW-1:0] found_tag;
  logic              accepted;

  // Local copy of the table and the screen width register.
  area_t             table_geom  [Areas];
  logic [CoordW-1:0] table_label [Areas];
  logic [CoordW-1:0] model_screen_width;

  hit_beat_t   pending_beats [$];
  hit_result_t owed_results  [$];
  area_t       recent_areas  [$];
  hit_beat_t   beat_on_port;
  hit_result_t oldest_owed;
  int          idle_left   = 0;
  int unsigned idle_pct    = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  rectangle_hit_region_table_top #(
    .AREA_COUNT(Areas)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .config_write(config_write),
    .config_data (config_data),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .x_position  (x_position),
    .y_position  (y_position),
    .align       (align),
    .area_width  (area_width),
    .area_height (area_height),
    .area_tag    (area_tag),
    .done        (done),
    .found_tag   (found_tag),
    .accepted    (accepted)
  );

  always #5 clk = ~clk;

  // Left edge of an area after alignment against the screen width.
  function automatic logic [CoordW-1:0] left_edge_for(logic [1:0] al, logic [CoordW-1:0] x,
                                                      logic [CoordW-1:0] w);
    int diff;
    int half;
    diff = int'(model_screen_width) - int'(w);
    half = diff / 2;
    case (al)
      AlignCentre: return half[CoordW-1:0];
      AlignRight:  return diff[CoordW-1:0];
      default:     return x;
    endcase
  endfunction

  // Works out the result of one beat and updates the local table.
  function automatic hit_result_t predict_hit(hit_beat_t b);
    hit_result_t       r;
    logic [CoordW-1:0] left;
    bit                done_scan;
    r.tag     = '0;
    r.ok      = 1'b1;
    done_scan = 1'b0;
    if (b.action == ActLookup) begin
      // First entry that holds the point, bounds inclusive and without wrap.
      for (int i = 0; i < Areas; i++) begin
        if (!done_scan && table_geom[i].left <= b.x && table_geom[i].top <= b.y &&
            (b.x - table_geom[i].left) <= table_geom[i].span_x &&
            (b.y - table_geom[i].top) <= table_geom[i].span_y) begin
          done_scan = 1'b1;
          r.tag     = table_label[i];
        end
      end
    end else if (b.align == AlignExplicit && b.x == '0 && b.y == '0 && b.w == '0 &&
                 b.tag == '0) begin
      // Clear command: tags go, geometry stays.
      for (int i = 0; i < Areas; i++) table_label[i] = '0;
    end else begin
      // Store into the first entry that has the exact geometry or is free.
      left = left_edge_for(b.align, b.x, b.w);
      for (int i = 0; i < Areas; i++) begin
        if (!done_scan) begin
          if (table_geom[i].left == left && table_geom[i].top == b.y &&
              table_geom[i].span_x == b.w && table_geom[i].span_y == b.h) begin
            table_label[i] = b.tag;
            done_scan      = 1'b1;
          end else if (table_label[i] == '0) begin
            table_geom[i]  = '{left: left, top: b.y, span_x: b.w, span_y: b.h};
            table_label[i] = b.tag;
            done_scan      = 1'b1;
          end
        end
      end
      r.ok = done_scan;
    end
    return r;
  endfunction

  function automatic void queue_beat(logic act, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                     logic [1:0] al, logic [CoordW-1:0] w,
                                     logic [CoordW-1:0] h, logic [CoordW-1:0] tag);
    pending_beats.push_back('{act, x, y, al, w, h, tag});
  endfunction

  // Random beat: mostly adds and lookups aimed at recently added areas, with
  // occasional clears and fully random noise.
  function automatic hit_beat_t random_beat();
    hit_beat_t   b;
    area_t       g;
    int unsigned pick;
    b    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      b.action = 1'($urandom_range(0, 1));
      b.x      = CoordW'($urandom_range(0, 65535));
      b.y      = CoordW'($urandom_range(0, 65535));
      b.align  = 2'($urandom_range(0, 3));
      b.w      = CoordW'($urandom_range(0, 65535));
      b.h      = CoordW'($urandom_range(0, 65535));
      b.tag    = CoordW'($urandom_range(0, 65535));
    end else if (pick < 12) begin
      b.action = ActAdd;
      b.align  = AlignExplicit;
      b.h      = CoordW'($urandom_range(0, 65535));
    end else if (pick < 55) begin
      b.action = ActAdd;
      if (recent_areas.size() != 0 && $urandom_range(0, 3) == 0) begin
        // Same geometry again, so only the tag is rewritten.
        g       = recent_areas[$urandom_range(0, recent_areas.size() - 1)];
        b.align = AlignExplicit;
        b.x     = g.left;
        b.y     = g.top;
        b.w     = g.span_x;
        b.h     = g.span_y;
      end else begin
        b.align = 2'($urandom_range(0, 3));
        b.x     = CoordW'($urandom_range(0, 1023));
        b.y     = CoordW'($urandom_range(0, 1023));
        b.w     = ($urandom_range(0, 3) == 0) ? CoordW'($urandom_range(0, 65535))
                                              : CoordW'($urandom_range(0, 255));
        b.h     = ($urandom_range(0, 3) == 0) ? CoordW'($urandom_range(0, 65535))
                                              : CoordW'($urandom_range(0, 255));
      end
      b.tag = ($urandom_range(0, 9) == 0) ? '0 : CoordW'($urandom_range(1, 65535));
      g     = '{left: left_edge_for(b.align, b.x, b.w), top: b.y, span_x: b.w, span_y: b.h};
      recent_areas.push_back(g);
      if (recent_areas.size() > Areas) void'(recent_areas.pop_front());
    end else begin
      b.action = ActLookup;
      if (recent_areas.size() != 0 && $urandom_range(0, 3) != 0) begin
        // Point inside the area or one step past its far edges.
        g   = recent_areas[$urandom_range(0, recent_areas.size() - 1)];
        b.x = CoordW'(g.left + $urandom_range(0, g.span_x + 1));
        b.y = CoordW'(g.top + $urandom_range(0, g.span_y + 1));
      end else begin
        b.x = CoordW'($urandom_range(0, 1023));
        b.y = CoordW'($urandom_range(0, 1023));
      end
    end
    return b;
  endfunction

  // Waits until the sender has nothing left and every result has arrived.
  task automatic drain();
    @(negedge clk);
    while (pending_beats.size() != 0 || start || owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_screen_width(logic [CoordW-1:0] value);
    @(posedge clk);
    config_write       <= 1'b1;
    config_data        <= value;
    model_screen_width  = value;
    @(posedge clk);
    config_write <= 1'b0;
    @(negedge clk);
  endtask

  // Sender: holds start until the beat is taken, then an optional idle burst.
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (!(start && busy)) begin
      if (start) owed_results.push_back(predict_hit(beat_on_port));
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        beat_on_port = pending_beats.pop_front();
        action      <= beat_on_port.action;
        x_position  <= beat_on_port.x;
        y_position  <= beat_on_port.y;
        align       <= beat_on_port.align;
        area_width  <= beat_on_port.w;
        area_height <= beat_on_port.h;
        area_tag    <= beat_on_port.tag;
        start       <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct) idle_left <= $urandom_range(1, 17);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Receiver: every result beat is compared with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Result beat with none owed: tag %h accepted %b", found_tag, accepted);
      end else begin
        oldest_owed = owed_results.pop_front();
        if (found_tag !== oldest_owed.tag || accepted !== oldest_owed.ok) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch: expected tag %h accepted %b, got tag %h accepted %b",
                     oldest_owed.tag, oldest_owed.ok, found_tag, accepted);
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [CoordW-1:0] phase_width;
    model_screen_width = LineWidthReset;
    for (int i = 0; i < Areas; i++) begin
      table_geom[i]  = '0;
      table_label[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats at the reset screen width of 640.
    idle_pct = 30;
    queue_beat(ActLookup, 16'd0, 16'd0, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActLookup, 16'hFFFF, 16'hFFFF, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'd10, 16'd20, AlignExplicit, 16'd30, 16'd40, 16'h1234);
    queue_beat(ActLookup, 16'd10, 16'd20, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActLookup, 16'd40, 16'd60, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActLookup, 16'd41, 16'd60, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActLookup, 16'd40, 16'd61, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'd10, 16'd20, AlignExplicit, 16'd30, 16'd40, 16'hBEEF);
    queue_beat(ActAdd, 16'd9, 16'd100, AlignCentre, 16'd100, 16'd5, 16'h0001);
    queue_beat(ActLookup, 16'd270, 16'd105, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'd0, 16'd3, AlignCentre, 16'd641, 16'd2, 16'h0002);
    queue_beat(ActAdd, 16'd0, 16'd7, AlignCentre, 16'hFFFF, 16'd9, 16'h0003);
    queue_beat(ActAdd, 16'd0, 16'd8, AlignRight, 16'd700, 16'd1, 16'h0004);
    queue_beat(ActAdd, 16'd500, 16'd500, AlignSpare, 16'd0, 16'd0, 16'h0005);
    queue_beat(ActLookup, 16'd500, 16'd500, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'hFFFF, 16'hFFFF, AlignExplicit, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(ActLookup, 16'hFFFF, 16'hFFFF, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'd0, 16'd0, AlignExplicit, 16'd0, 16'd0, 16'h8000);
    queue_beat(ActLookup, 16'd0, 16'd0, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'd1, 16'd0, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'd0, 16'd0, AlignExplicit, 16'd0, 16'd1234, 16'd0);
    queue_beat(ActLookup, 16'd10, 16'd20, AlignExplicit, 16'd0, 16'd0, 16'd0);
    queue_beat(ActAdd, 16'd0, 16'd0, AlignRight, 16'd0, 16'd0, 16'd0);
    queue_beat(ActLookup, 16'd640, 16'd0, AlignExplicit, 16'd0, 16'd0, 16'd0);
    drain();

    // Random phases, each at its own screen width; the last runs without idling.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          phase_width = '0;
          idle_pct    = 30;
        end
        1: begin
          phase_width = 16'hFFFF;
          idle_pct    = 0;
        end
        2: begin
          phase_width = 16'd1;
          idle_pct    = 50;
        end
        3: begin
          phase_width = CoordW'($urandom_range(0, 65535));
          idle_pct    = 30;
        end
        default: begin
          phase_width = LineWidthReset;
          idle_pct    = 0;
        end
      endcase
      write_screen_width(phase_width);
      recent_areas.delete();
      for (int n = 0; n < PhaseBeats; n++) pending_beats.push_back(random_beat());
      drain();
    end

    repeat (Areas + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
